>>> hdl/bpbs_pkg.sv
// Shared types, constants and the per-byte scrambling function.
`default_nettype none
package bpbs_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W = 8;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] BLOCK_SIZE_RST = 8'd4;
    localparam logic [1:0] PHASE_LAST = 2'd2;

    typedef enum logic [0:0] {
        CFG_BLOCK_SIZE = 1'b0,
        CFG_DIRECTION  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RULE_ALL   = 2'd0,
        RULE_EVEN  = 2'd1,
        RULE_THIRD = 2'd2
    } t_rule;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] coded_byte;
        logic       end_of_message_out;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] block_size;
        logic       direction;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] bit_position;
        logic [CNT_W-1:0] ones_in_block;
        logic [CNT_W-1:0] zeros_in_block;
        t_rule            flip_rule;
        logic [1:0]       phase_mod_three;
    } t_blk_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        t_blk_state       st;
        logic [BYTE_W-1:0] dout;
    } t_step;

    localparam t_blk_state BLK_STATE_RST = '{
        bit_position: '0, ones_in_block: '0, zeros_in_block: '0,
        flip_rule: RULE_ALL, phase_mod_three: '0};

    function automatic t_step scramble_byte(t_blk_state s_in, logic [BYTE_W-1:0] din,
                                            t_cfg cfg);
        t_blk_state s;
        t_step      r;
        logic [7:0] size;
        logic       ib;
        logic       flip;
        logic       ob;
        logic       plain;
        s = s_in;
        r.dout = '0;
        size = (cfg.block_size == 8'd0) ? 8'd1 : cfg.block_size;
        for (int k = 0; k < BYTE_W; k++) begin
            ib = din[BYTE_W-1-k];
            case (s.flip_rule)
                RULE_ALL:  flip = 1'b1;
                RULE_EVEN: flip = s.bit_position[0];
                default:   flip = (s.phase_mod_three == PHASE_LAST);
            endcase
            ob = ib ^ flip;
            r.dout[BYTE_W-1-k] = ob;
            plain = cfg.direction ? ob : ib;
            if (plain) begin
                s.ones_in_block = s.ones_in_block + 1'b1;
            end else begin
                s.zeros_in_block = s.zeros_in_block + 1'b1;
            end
            if (({1'b0, s.bit_position} + 9'd1) >= {1'b0, size}) begin
                if (s.ones_in_block == s.zeros_in_block) begin
                    s.flip_rule = RULE_ALL;
                end else if (s.zeros_in_block > s.ones_in_block) begin
                    s.flip_rule = RULE_EVEN;
                end else begin
                    s.flip_rule = RULE_THIRD;
                end
                s.bit_position = '0;
                s.phase_mod_three = '0;
                s.ones_in_block = '0;
                s.zeros_in_block = '0;
            end else begin
                s.bit_position = s.bit_position + 1'b1;
                s.phase_mod_three = (s.phase_mod_three == PHASE_LAST) ? 2'd0
                                    : s.phase_mod_three + 2'd1;
            end
        end
        r.st = s;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/bpbs_front.sv
// Front stage: takes input beats into a holding register and feeds the queue.
`default_nettype none
module bpbs_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire bpbs_pkg::t_in_beat i_in_data,
    input  wire bpbs_pkg::t_q_status i_q_status,
    output logic                   o_push,
    output bpbs_pkg::t_in_beat     o_push_data
);

    logic               r_valid;
    bpbs_pkg::t_in_beat r_beat;
    logic               load;

    assign o_push      = r_valid && !i_q_status.full;
    assign o_push_data = r_beat;
    assign o_in_stall  = r_valid && i_q_status.full;
    assign load        = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= i_in_data;
        end
    end

endmodule
`default_nettype wire

>>> hdl/bpbs_queue.sv
// Short FIFO between front and back stages.
`default_nettype none
module bpbs_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire bpbs_pkg::t_in_beat i_push_data,
    input  wire logic               i_pop,
    output bpbs_pkg::t_in_beat      o_head,
    output bpbs_pkg::t_q_status     o_status
);

    bpbs_pkg::t_in_beat                  r_mem [bpbs_pkg::Q_DEPTH];
    logic [bpbs_pkg::Q_PTR_W-1:0]        r_wr_ptr;
    logic [bpbs_pkg::Q_PTR_W-1:0]        r_rd_ptr;
    logic [bpbs_pkg::Q_CNT_W-1:0]        r_count;

    assign o_status.full  = (r_count == bpbs_pkg::Q_CNT_W'(bpbs_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == bpbs_pkg::Q_PTR_W'(bpbs_pkg::Q_DEPTH - 1)) ? '0
                            : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == bpbs_pkg::Q_PTR_W'(bpbs_pkg::Q_DEPTH - 1)) ? '0
                            : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

>>> hdl/bpbs_back.sv
// Back stage: scrambles one byte per cycle while fed and not stalled, and holds the result beat.
`default_nettype none
module bpbs_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bpbs_pkg::t_cfg      i_cfg,
    input  wire bpbs_pkg::t_q_status i_q_status,
    input  wire bpbs_pkg::t_in_beat  i_head,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output bpbs_pkg::t_out_beat      o_out_data
);

    bpbs_pkg::t_blk_state r_st;
    bpbs_pkg::t_blk_state n_st;
    logic                 r_valid;
    bpbs_pkg::t_out_beat  r_out;
    bpbs_pkg::t_step      step;
    logic                 load;

    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !i_q_status.empty;
    assign step  = bpbs_pkg::scramble_byte(r_st, i_head.data_byte, i_cfg);

    always_comb begin
        n_st = r_st;
        if (o_pop) begin
            n_st = i_head.end_of_message ? bpbs_pkg::BLK_STATE_RST : step.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= bpbs_pkg::BLK_STATE_RST;
            r_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load) begin
                r_valid <= o_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.coded_byte         <= step.dout;
            r_out.end_of_message_out <= i_head.end_of_message;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

>>> hdl/block_parity_bit_scrambler.sv
// Top level of the block parity bit scrambler.
//  channel | direction | handshake                 | beat
//  in      | input     | i_in_valid / o_in_stall   | t_in_beat
//  out     | output    | o_out_valid / i_out_stall | t_out_beat
//  cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_wdata
// One byte per cycle unless a side stalls; the eight bit decisions of a byte
// resolve combinationally in the back stage. With an empty queue an accepted
// beat passes the front register, a queue entry and the back output register.
// Synchronous active-low reset clears block state, queue and valids; block_size
// resets to 4, direction to encode. Front and back stall independently across
// a two-entry queue.
`default_nettype none
module block_parity_bit_scrambler (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire bpbs_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output bpbs_pkg::t_out_beat      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire bpbs_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [7:0]          i_cfg_wdata
);

    bpbs_pkg::t_cfg      r_cfg;
    bpbs_pkg::t_q_status q_status;
    bpbs_pkg::t_in_beat  push_data;
    bpbs_pkg::t_in_beat  head;
    logic                push;
    logic                pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_size <= bpbs_pkg::BLOCK_SIZE_RST;
            r_cfg.direction  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bpbs_pkg::CFG_BLOCK_SIZE: r_cfg.block_size <= i_cfg_wdata;
                bpbs_pkg::CFG_DIRECTION:  r_cfg.direction  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    bpbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    bpbs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    bpbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_q_status_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("push into full queue");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

endmodule
`default_nettype wire

>>> sim/block_parity_bit_scrambler_test.sv
// Self-checking testbench for the block parity bit scrambler: directed, random and backpressure.
`default_nettype none
module block_parity_bit_scrambler_test;
    import bpbs_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_beat   in_data   = '0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_beat  out_data;
    logic       cfg_we    = 1'b0;
    t_cfg_idx   cfg_index = CFG_BLOCK_SIZE;
    logic [7:0] cfg_wdata = '0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    logic hold_armed  = 1'b0;
    int hold_count    = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    // predicted block state and register copies
    logic [7:0] pred_size   = BLOCK_SIZE_RST;
    logic       pred_decode = 1'b0;
    logic [7:0] pred_pos    = '0;
    logic [7:0] pred_ones   = '0;
    logic [7:0] pred_zeros  = '0;
    t_rule      pred_rule   = RULE_ALL;
    logic [1:0] pred_phase  = '0;

    t_out_beat pending_coded[$];

    block_parity_bit_scrambler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic predict_coded_byte(input t_in_beat beat);
        t_out_beat res;
        int        eff_size;
        logic      in_b;
        logic      flip;
        logic      out_b;
        logic      plain;
        eff_size = (pred_size == 8'd0) ? 1 : int'(pred_size);
        res = '0;
        for (int k = 7; k >= 0; k--) begin
            in_b = beat.data_byte[k];
            if (pred_rule == RULE_ALL) begin
                flip = 1'b1;
            end else if (pred_rule == RULE_EVEN) begin
                flip = pred_pos[0];
            end else begin
                flip = (pred_phase == PHASE_LAST);
            end
            out_b = in_b ^ flip;
            res.coded_byte[k] = out_b;
            plain = pred_decode ? out_b : in_b;
            if (plain) begin
                pred_ones = pred_ones + 8'd1;
            end else begin
                pred_zeros = pred_zeros + 8'd1;
            end
            if (int'(pred_pos) + 1 >= eff_size) begin
                if (pred_ones == pred_zeros) begin
                    pred_rule = RULE_ALL;
                end else if (pred_zeros > pred_ones) begin
                    pred_rule = RULE_EVEN;
                end else begin
                    pred_rule = RULE_THIRD;
                end
                pred_pos   = '0;
                pred_phase = '0;
                pred_ones  = '0;
                pred_zeros = '0;
            end else begin
                pred_pos   = pred_pos + 8'd1;
                pred_phase = (pred_phase == PHASE_LAST) ? 2'd0 : pred_phase + 2'd1;
            end
        end
        res.end_of_message_out = beat.end_of_message;
        pending_coded.push_back(res);
        if (beat.end_of_message) begin
            pred_pos   = '0;
            pred_ones  = '0;
            pred_zeros = '0;
            pred_rule  = RULE_ALL;
            pred_phase = '0;
        end
    endtask

    task automatic send_beat(input logic [7:0] data, input logic eom);
        t_in_beat beat;
        beat.data_byte      = data;
        beat.end_of_message = eom;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
        predict_coded_byte(beat);
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_coded.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        drain_pipeline();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_SIZE) begin
            pred_size = val;
        end else begin
            pred_decode = val[0];
        end
    endtask

    task automatic test_reset_defaults();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'hA5, 1'b1);
    endtask

    task automatic test_block_size_one();
        write_reg(CFG_BLOCK_SIZE, 8'd1);
        send_beat(8'h3C, 1'b0);
        send_beat(8'hC3, 1'b1);
    endtask

    // size 0 behaves as size 1
    task automatic test_zero_block_size();
        write_reg(CFG_BLOCK_SIZE, 8'd0);
        send_beat(8'h3C, 1'b0);
        send_beat(8'h96, 1'b1);
    endtask

    // message ends inside one long block
    task automatic test_long_block();
        write_reg(CFG_BLOCK_SIZE, 8'd255);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h0F, 1'b0);
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_decode_direction();
        write_reg(CFG_BLOCK_SIZE, 8'd5);
        write_reg(CFG_DIRECTION, 8'hFF);
        send_beat(8'h5A, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hE7, 1'b1);
    endtask

    // shrink the block below the current position mid-message
    task automatic test_mid_block_resize();
        write_reg(CFG_DIRECTION, 8'h00);
        write_reg(CFG_BLOCK_SIZE, 8'd20);
        send_beat(8'hF0, 1'b0);
        write_reg(CFG_BLOCK_SIZE, 8'd3);
        send_beat(8'h0F, 1'b0);
        send_beat(8'hAA, 1'b1);
    endtask

    task automatic test_end_of_message();
        write_reg(CFG_BLOCK_SIZE, 8'd6);
        send_beat(8'h81, 1'b1);
        send_beat(8'h81, 1'b1);
        send_beat(8'h7E, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_p, input int n_items);
        logic [7:0] size;
        logic [7:0] data;
        send_idle_pct = idle_pct;
        stall_pct     = stall_p;
        for (int seg = 0; seg < 4; seg++) begin
            case ($urandom_range(9))
                0:       size = 8'd0;
                1:       size = 8'd255;
                2:       size = 8'd1;
                3, 4:    size = 8'($urandom_range(255));
                default: size = 8'($urandom_range(16, 2));
            endcase
            write_reg(CFG_BLOCK_SIZE, size);
            write_reg(CFG_DIRECTION, 8'($urandom_range(255)));
            for (int i = 0; i < n_items / 4; i++) begin
                case ($urandom_range(7))
                    0:       data = 8'h00;
                    1:       data = 8'hFF;
                    default: data = 8'($urandom_range(255));
                endcase
                send_beat(data, $urandom_range(9) == 0);
            end
        end
    endtask

    task automatic test_backpressure();
        drain_pipeline();
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge clk);
        hold_armed = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
        end
    endtask

    always @(negedge clk) begin
        if (hold_armed && hold_count < HOLD_CYCLES) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin : check_coded
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_coded.size() == 0) begin
                $error("coded beat %02h with none expected", out_data.coded_byte);
                error_count++;
            end else begin
                want = pending_coded.pop_front();
                if (out_data.coded_byte !== want.coded_byte) begin
                    $error("coded_byte: expected %02h, got %02h",
                           want.coded_byte, out_data.coded_byte);
                    error_count++;
                end
                if (out_data.end_of_message_out !== want.end_of_message_out) begin
                    $error("end_of_message_out: expected %0b, got %0b",
                           want.end_of_message_out, out_data.end_of_message_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("block_parity_bit_scrambler_test: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_block_size_one();
        test_zero_block_size();
        test_long_block();
        test_decode_direction();
        test_mid_block_resize();
        test_end_of_message();
        test_random_traffic(0, 0, 100);
        test_random_traffic(87, 0, 100);
        test_random_traffic(0, 87, 100);
        test_random_traffic(33, 33, 100);
        test_backpressure();
        drain_pipeline();
        if (error_count == 0) begin
            $display("block_parity_bit_scrambler_test: clean");
        end else begin
            $display("block_parity_bit_scrambler_test: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> block_parity_bit_scrambler.f
hdl/bpbs_pkg.sv
hdl/bpbs_front.sv
hdl/bpbs_queue.sv
hdl/bpbs_back.sv
hdl/block_parity_bit_scrambler.sv
sim/block_parity_bit_scrambler_test.sv
